>>> rtl/esc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants for the environmental sensor compensation block.
// ----------------------------------------------------------------------------
package esc_pkg;

	localparam int FRONT_STAGES = 14;
	localparam int DIV_STEPS    = 64;
	localparam int BACK_STAGES  = 7;

	localparam int CFG_IDX_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_TEMP_COEFFS   = 32'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_FIRST   = 32'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_SECOND  = 32'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_NINTH   = 32'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HUM_COEFFS    = 32'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HUM_ENABLE    = 32'd5;

	localparam logic [31:0] HUM_MAX = 32'd419430400;

	typedef struct packed {
		logic [19:0] raw_temperature;
		logic [19:0] raw_pressure;
		logic [15:0] raw_humidity;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] temperature_centi;
		logic [31:0]        pressure_q24_8;
		logic [16:0]        humidity_q22_10;
		logic               pressure_divisor_zero;
	} result_t;

	// fields that ride along with the divider
	typedef struct packed {
		logic [31:0] temperature;
		logic [16:0] humidity;
		logic        divisor_zero;
	} side_t;

	typedef struct packed {
		logic [63:0] dividend_mag;
		logic [30:0] divisor_mag;
		logic        quot_neg;
		side_t       side;
	} div_req_t;

	typedef struct packed {
		logic [63:0] quotient_mag;
		logic        quot_neg;
		side_t       side;
	} div_rsp_t;

endpackage

>>> rtl/esc_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_divider
// Pipelined restoring divider, one quotient bit per stage, unsigned magnitudes.
// ----------------------------------------------------------------------------
module esc_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  esc_pkg::div_req_t   req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output esc_pkg::div_rsp_t   rsp
);

	localparam int N = esc_pkg::DIV_STEPS;

	logic [N-1:0]  vld_s;
	logic [N:0]    adv;
	logic [30:0]   rem_s  [N];
	logic [63:0]   num_s  [N];
	logic [30:0]   ud_s   [N];
	logic          neg_s  [N];
	esc_pkg::side_t side_s [N];

	assign adv[N] = rsp_ready;
	assign req_ready = adv[0];

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [30:0]    rem_src;
		logic [63:0]    num_src;
		logic [30:0]    ud_src;
		logic           neg_src;
		esc_pkg::side_t side_src;
		logic           vld_src;
		logic [31:0]    trial;
		logic [31:0]    diff;
		logic           take;

		if (k == 0) begin : g_first
			assign rem_src  = '0;
			assign num_src  = req.dividend_mag;
			assign ud_src   = req.divisor_mag;
			assign neg_src  = req.quot_neg;
			assign side_src = req.side;
			assign vld_src  = req_valid;
		end else begin : g_next
			assign rem_src  = rem_s[k-1];
			assign num_src  = num_s[k-1];
			assign ud_src   = ud_s[k-1];
			assign neg_src  = neg_s[k-1];
			assign side_src = side_s[k-1];
			assign vld_src  = vld_s[k-1];
		end

		assign trial = {rem_src, num_src[63]};
		assign diff  = trial - {1'b0, ud_src};
		assign take  = trial >= {1'b0, ud_src};
		assign adv[k] = !vld_s[k] || adv[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv[k]) begin
				vld_s[k] <= vld_src;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k]) begin
				rem_s[k]  <= take ? diff[30:0] : trial[30:0];
				num_s[k]  <= {num_src[62:0], take};
				ud_s[k]   <= ud_src;
				neg_s[k]  <= neg_src;
				side_s[k] <= side_src;
			end
		end
	end

	assign rsp_valid         = vld_s[N-1];
	assign rsp.quotient_mag  = num_s[N-1];
	assign rsp.quot_neg      = neg_s[N-1];
	assign rsp.side          = side_s[N-1];

endmodule

>>> rtl/env_sensor_compensation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// env_sensor_compensation
// Integer compensation of raw temperature, pressure and humidity samples.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel   : writes one calibration register per transaction (index,
//                   data); always ready. Write only while the pipe is empty.
//   sample channel: one raw triple per transaction, valid/ready.
//   result channel: one compensated record per sample, in order, valid/ready.
// Throughput: one sample per cycle, sustained while result_ready stays high.
// Pipeline: 14 stages of multiply/add front end, 64 stages of the
//   one-bit-per-stage pressure divider, 7 stages of pressure finishing.
// Stall: each stage holds while the one after it is full and stalled, so
//   empty stages keep filling; sample_ready drops only when every stage holds
//   a transaction and result_ready is low.
// Reset: pipeline emptied, calibration registers cleared, humidity enabled.
// ----------------------------------------------------------------------------
module env_sensor_compensation (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [esc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [63:0]                     cfg_data,
	input  logic                            sample_valid,
	output logic                            sample_ready,
	input  esc_pkg::sample_t                sample,
	output logic                            result_valid,
	input  logic                            result_ready,
	output esc_pkg::result_t                result
);

	localparam int FS = esc_pkg::FRONT_STAGES;
	localparam int BS = esc_pkg::BACK_STAGES;

	// ---------------- configuration ----------------
	logic [47:0] temp_coeffs_q;
	logic [63:0] press_first_q;
	logic [63:0] press_second_q;
	logic [15:0] press_ninth_q;
	logic [63:0] hum_coeffs_q;
	logic        hum_en_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coeffs_q  <= '0;
			press_first_q  <= '0;
			press_second_q <= '0;
			press_ninth_q  <= '0;
			hum_coeffs_q   <= '0;
			hum_en_q       <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				esc_pkg::REG_TEMP_COEFFS:  temp_coeffs_q  <= cfg_data[47:0];
				esc_pkg::REG_PRESS_FIRST:  press_first_q  <= cfg_data;
				esc_pkg::REG_PRESS_SECOND: press_second_q <= cfg_data;
				esc_pkg::REG_PRESS_NINTH:  press_ninth_q  <= cfg_data[15:0];
				esc_pkg::REG_HUM_COEFFS:   hum_coeffs_q   <= cfg_data;
				esc_pkg::REG_HUM_ENABLE:   hum_en_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	logic [15:0] t1, p1, p2, p3, p4, p5, p6, p7, p8, p9, h2;
	logic [31:0] t2x, t3x, h6x, h3x, h5x32, h2x, h1x;
	logic [11:0] h4;
	assign t1  = temp_coeffs_q[15:0];
	assign t2x = {{16{temp_coeffs_q[31]}}, temp_coeffs_q[31:16]};
	assign t3x = {{16{temp_coeffs_q[47]}}, temp_coeffs_q[47:32]};
	assign p1  = press_first_q[15:0];
	assign p2  = press_first_q[31:16];
	assign p3  = press_first_q[47:32];
	assign p4  = press_first_q[63:48];
	assign p5  = press_second_q[15:0];
	assign p6  = press_second_q[31:16];
	assign p7  = press_second_q[47:32];
	assign p8  = press_second_q[63:48];
	assign p9  = press_ninth_q;
	assign h1x = {24'd0, hum_coeffs_q[7:0]};
	assign h2  = hum_coeffs_q[23:8];
	assign h2x = {{16{h2[15]}}, h2};
	assign h3x = {24'd0, hum_coeffs_q[31:24]};
	assign h4  = hum_coeffs_q[43:32];
	assign h5x32 = {{20{hum_coeffs_q[55]}}, hum_coeffs_q[55:44]};
	assign h6x = {{24{hum_coeffs_q[63]}}, hum_coeffs_q[63:56]};

	// ---------------- front pipeline control ----------------
	logic [FS-1:0] f_vld;
	logic [FS:0]   f_adv;
	logic          div_req_ready;

	assign f_adv[FS]    = div_req_ready;
	assign sample_ready = f_adv[0];

	for (genvar k = 0; k < FS; k++) begin : g_front
		assign f_adv[k] = !f_vld[k] || f_adv[k+1];
		if (k == 0) begin : g_head
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					f_vld[k] <= 1'b0;
				end else if (f_adv[k]) begin
					f_vld[k] <= sample_valid;
				end
			end
		end else begin : g_tail
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					f_vld[k] <= 1'b0;
				end else if (f_adv[k]) begin
					f_vld[k] <= f_vld[k-1];
				end
			end
		end
	end

	// ---------------- S1: temperature differences ----------------
	logic [31:0] a_s1, b_s1;
	logic [19:0] rawp_s1;
	logic [15:0] rawh_s1;
	always_ff @(posedge clk) begin
		if (f_adv[0]) begin
			a_s1    <= {15'd0, sample.raw_temperature[19:3]} - {15'd0, t1, 1'b0};
			b_s1    <= {16'd0, sample.raw_temperature[19:4]} - {16'd0, t1};
			rawp_s1 <= sample.raw_pressure;
			rawh_s1 <= sample.raw_humidity;
		end
	end

	// ---------------- S2 ----------------
	logic [31:0] m1_s2, bb_s2;
	logic [19:0] rawp_s2;
	logic [15:0] rawh_s2;
	always_ff @(posedge clk) begin
		if (f_adv[1]) begin
			m1_s2   <= a_s1 * t2x;
			bb_s2   <= b_s1 * b_s1;
			rawp_s2 <= rawp_s1;
			rawh_s2 <= rawh_s1;
		end
	end

	// ---------------- S3 ----------------
	logic [31:0] v1_c, bb_sh_c;
	assign v1_c    = $signed(m1_s2) >>> 11;
	assign bb_sh_c = $signed(bb_s2) >>> 12;

	logic [31:0] v1_s3, m2_s3;
	logic [19:0] rawp_s3;
	logic [15:0] rawh_s3;
	always_ff @(posedge clk) begin
		if (f_adv[2]) begin
			v1_s3   <= v1_c;
			m2_s3   <= bb_sh_c * t3x;
			rawp_s3 <= rawp_s2;
			rawh_s3 <= rawh_s2;
		end
	end

	// ---------------- S4: fine temperature ----------------
	logic [31:0] v2_c;
	assign v2_c = $signed(m2_s3) >>> 14;

	logic [31:0] tf_s4;
	logic [19:0] rawp_s4;
	logic [15:0] rawh_s4;
	always_ff @(posedge clk) begin
		if (f_adv[3]) begin
			tf_s4   <= v1_s3 + v2_c;
			rawp_s4 <= rawp_s3;
			rawh_s4 <= rawh_s3;
		end
	end

	// ---------------- S5 ----------------
	logic [31:0] t5_c, temp_c;
	assign t5_c   = tf_s4 + {tf_s4[29:0], 2'b00} + 32'd128;
	assign temp_c = $signed(t5_c) >>> 8;

	logic [31:0] temp_s5, x_s5;
	logic [32:0] w1_s5;
	logic [19:0] rawp_s5;
	logic [15:0] rawh_s5;
	always_ff @(posedge clk) begin
		if (f_adv[4]) begin
			temp_s5 <= temp_c;
			w1_s5   <= {tf_s4[31], tf_s4} - 33'd128000;
			x_s5    <= tf_s4 - 32'd76800;
			rawp_s5 <= rawp_s4;
			rawh_s5 <= rawh_s4;
		end
	end

	// ---------------- S6 ----------------
	logic [63:0] w1x64_c;
	logic [47:0] w1x48_c;
	assign w1x64_c = {{31{w1_s5[32]}}, w1_s5};
	assign w1x48_c = {{15{w1_s5[32]}}, w1_s5};

	logic [63:0] sq_s6;
	logic [47:0] wp5_s6, wp2_s6;
	logic [31:0] hx6_s6, hx3_s6, h5x_s6, temp_s6;
	logic [19:0] rawp_s6;
	logic [15:0] rawh_s6;
	always_ff @(posedge clk) begin
		if (f_adv[5]) begin
			sq_s6   <= w1x64_c * w1x64_c;
			wp5_s6  <= w1x48_c * {{32{p5[15]}}, p5};
			wp2_s6  <= w1x48_c * {{32{p2[15]}}, p2};
			hx6_s6  <= x_s5 * h6x;
			hx3_s6  <= x_s5 * h3x;
			h5x_s6  <= h5x32 * x_s5;
			temp_s6 <= temp_s5;
			rawp_s6 <= rawp_s5;
			rawh_s6 <= rawh_s5;
		end
	end

	// ---------------- S7: 64-bit products split in halves ----------------
	logic [31:0] hx6_sh_c, hx3_sh_c, f1_sum_c, f1_c;
	assign hx6_sh_c = $signed(hx6_s6) >>> 10;
	assign hx3_sh_c = $signed(hx3_s6) >>> 11;
	assign f1_sum_c = {2'd0, rawh_s6, 14'd0} - {h4, 20'd0} - h5x_s6 + 32'd16384;
	assign f1_c     = $signed(f1_sum_c) >>> 15;

	logic [47:0] pp6lo_s7, pp3lo_s7, wp5_s7, wp2_s7;
	logic [31:0] pp6hi_s7, pp3hi_s7, g1_s7, f1_s7, temp_s7;
	logic [19:0] rawp_s7;
	always_ff @(posedge clk) begin
		if (f_adv[6]) begin
			pp6lo_s7 <= {16'd0, sq_s6[31:0]} * {{32{p6[15]}}, p6};
			pp6hi_s7 <= sq_s6[63:32] * {{16{p6[15]}}, p6};
			pp3lo_s7 <= {16'd0, sq_s6[31:0]} * {{32{p3[15]}}, p3};
			pp3hi_s7 <= sq_s6[63:32] * {{16{p3[15]}}, p3};
			g1_s7    <= hx6_sh_c * (hx3_sh_c + 32'd32768);
			f1_s7    <= f1_c;
			wp5_s7   <= wp5_s6;
			wp2_s7   <= wp2_s6;
			temp_s7  <= temp_s6;
			rawp_s7  <= rawp_s6;
		end
	end

	// ---------------- S8 ----------------
	logic [31:0] g1_sh_c;
	assign g1_sh_c = $signed(g1_s7) >>> 10;

	logic [63:0] w2_s8, m3_s8;
	logic [47:0] wp2_s8;
	logic [31:0] g_s8, f1_s8, temp_s8;
	logic [19:0] rawp_s8;
	always_ff @(posedge clk) begin
		if (f_adv[7]) begin
			w2_s8   <= {{16{pp6lo_s7[47]}}, pp6lo_s7} + {pp6hi_s7, 32'd0}
				+ {wp5_s7[46:0], 17'd0} + {{13{p4[15]}}, p4, 35'd0};
			m3_s8   <= {{16{pp3lo_s7[47]}}, pp3lo_s7} + {pp3hi_s7, 32'd0};
			g_s8    <= g1_sh_c + 32'd2097152;
			wp2_s8  <= wp2_s7;
			f1_s8   <= f1_s7;
			temp_s8 <= temp_s7;
			rawp_s8 <= rawp_s7;
		end
	end

	// ---------------- S9 ----------------
	logic [63:0] m3_sh_c;
	logic [20:0] pinv_c;
	assign m3_sh_c = $signed(m3_s8) >>> 8;
	assign pinv_c  = 21'h100000 - {1'b0, rawp_s8};

	logic [63:0] w1c_s9, n0_s9;
	logic [31:0] gh_s9, f1_s9, temp_s9;
	always_ff @(posedge clk) begin
		if (f_adv[8]) begin
			w1c_s9  <= m3_sh_c + {wp2_s8[47], wp2_s8[47], wp2_s8[47], wp2_s8[47],
				wp2_s8, 12'd0} + 64'h0000_8000_0000_0000;
			n0_s9   <= {12'd0, pinv_c, 31'd0} - w2_s8;
			gh_s9   <= g_s8 * h2x;
			f1_s9   <= f1_s8;
			temp_s9 <= temp_s8;
		end
	end

	// ---------------- S10 ----------------
	logic [31:0] gh_rnd_c, f2_c;
	assign gh_rnd_c = gh_s9 + 32'd8192;
	assign f2_c     = $signed(gh_rnd_c) >>> 14;

	logic [47:0] ml_s10;
	logic [43:0] nl_s10;
	logic [31:0] mh_s10, nh_s10, f1_s10, f2_s10, temp_s10;
	always_ff @(posedge clk) begin
		if (f_adv[9]) begin
			ml_s10   <= {16'd0, w1c_s9[31:0]} * {32'd0, p1};
			mh_s10   <= w1c_s9[63:32] * {16'd0, p1};
			nl_s10   <= {12'd0, n0_s9[31:0]} * 44'd3125;
			nh_s10   <= n0_s9[63:32] * 32'd3125;
			f1_s10   <= f1_s9;
			f2_s10   <= f2_c;
			temp_s10 <= temp_s9;
		end
	end

	// ---------------- S11 ----------------
	logic [63:0] prod1_c;
	assign prod1_c = {16'd0, ml_s10} + {mh_s10, 32'd0};

	logic [30:0] d_s11;
	logic [63:0] n_s11;
	logic [31:0] r_s11, temp_s11;
	always_ff @(posedge clk) begin
		if (f_adv[10]) begin
			d_s11    <= prod1_c[63:33];
			n_s11    <= {20'd0, nl_s10} + {nh_s10, 32'd0};
			r_s11    <= f1_s10 * f2_s10;
			temp_s11 <= temp_s10;
		end
	end

	// ---------------- S12: magnitudes for the divider ----------------
	logic [31:0] s_c;
	assign s_c = $signed(r_s11) >>> 15;

	logic [63:0] un_s12;
	logic [30:0] ud_s12;
	logic        qneg_s12, dz_s12;
	logic [31:0] r_s12, ss_s12, temp_s12;
	always_ff @(posedge clk) begin
		if (f_adv[11]) begin
			un_s12   <= n_s11[63] ? 64'd0 - n_s11 : n_s11;
			ud_s12   <= d_s11[30] ? 31'd0 - d_s11 : d_s11;
			qneg_s12 <= n_s11[63] ^ d_s11[30];
			dz_s12   <= d_s11 == 31'd0;
			r_s12    <= r_s11;
			ss_s12   <= s_c * s_c;
			temp_s12 <= temp_s11;
		end
	end

	// ---------------- S13 ----------------
	logic [31:0] ss_sh_c;
	assign ss_sh_c = $signed(ss_s12) >>> 7;

	logic [63:0] un_s13;
	logic [30:0] ud_s13;
	logic        qneg_s13, dz_s13;
	logic [31:0] r_s13, hm_s13, temp_s13;
	always_ff @(posedge clk) begin
		if (f_adv[12]) begin
			un_s13   <= un_s12;
			ud_s13   <= ud_s12;
			qneg_s13 <= qneg_s12;
			dz_s13   <= dz_s12;
			r_s13    <= r_s12;
			hm_s13   <= ss_sh_c * h1x;
			temp_s13 <= temp_s12;
		end
	end

	// ---------------- S14: humidity clamp ----------------
	logic [31:0] hm_sh_c, r2_c, r2c_c;
	assign hm_sh_c = $signed(hm_s13) >>> 4;
	assign r2_c    = r_s13 - hm_sh_c;
	always_comb begin
		if (r2_c[31]) begin
			r2c_c = 32'd0;
		end else if (r2_c > esc_pkg::HUM_MAX) begin
			r2c_c = esc_pkg::HUM_MAX;
		end else begin
			r2c_c = r2_c;
		end
	end

	logic [63:0] un_s14;
	logic [30:0] ud_s14;
	logic        qneg_s14, dz_s14;
	logic [16:0] hum_s14;
	logic [31:0] temp_s14;
	always_ff @(posedge clk) begin
		if (f_adv[13]) begin
			un_s14   <= un_s13;
			ud_s14   <= ud_s13;
			qneg_s14 <= qneg_s13;
			dz_s14   <= dz_s13;
			hum_s14  <= hum_en_q ? r2c_c[28:12] : 17'd0;
			temp_s14 <= temp_s13;
		end
	end

	// ---------------- divider ----------------
	esc_pkg::div_req_t div_req;
	esc_pkg::div_rsp_t div_rsp;
	logic              div_rsp_valid, div_rsp_ready;

	assign div_req.dividend_mag      = un_s14;
	assign div_req.divisor_mag       = ud_s14;
	assign div_req.quot_neg          = qneg_s14;
	assign div_req.side.temperature  = temp_s14;
	assign div_req.side.humidity     = hum_s14;
	assign div_req.side.divisor_zero = dz_s14;

	esc_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (f_vld[FS-1]),
		.req_ready (div_req_ready),
		.req       (div_req),
		.rsp_valid (div_rsp_valid),
		.rsp_ready (div_rsp_ready),
		.rsp       (div_rsp)
	);

	// ---------------- back pipeline control ----------------
	logic [BS-1:0] b_vld;
	logic [BS:0]   b_adv;

	assign b_adv[BS]     = result_ready;
	assign div_rsp_ready = b_adv[0];

	for (genvar k = 0; k < BS; k++) begin : g_back
		assign b_adv[k] = !b_vld[k] || b_adv[k+1];
		if (k == 0) begin : g_head
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					b_vld[k] <= 1'b0;
				end else if (b_adv[k]) begin
					b_vld[k] <= div_rsp_valid;
				end
			end
		end else begin : g_tail
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					b_vld[k] <= 1'b0;
				end else if (b_adv[k]) begin
					b_vld[k] <= b_vld[k-1];
				end
			end
		end
	end

	// B1: signed quotient
	logic [63:0]    bp_s1;
	esc_pkg::side_t bside_s1;
	always_ff @(posedge clk) begin
		if (b_adv[0]) begin
			bp_s1    <= div_rsp.quot_neg ? 64'd0 - div_rsp.quotient_mag
				: div_rsp.quotient_mag;
			bside_s1 <= div_rsp.side;
		end
	end

	// B2
	logic [63:0] by_c;
	assign by_c = $signed(bp_s1) >>> 13;

	logic [63:0]    bp_s2, by_s2;
	logic [47:0]    p8l_s2, y9l_s2;
	logic [31:0]    p8h_s2, y9h_s2;
	esc_pkg::side_t bside_s2;
	always_ff @(posedge clk) begin
		if (b_adv[1]) begin
			p8l_s2   <= {16'd0, bp_s1[31:0]} * {{32{p8[15]}}, p8};
			p8h_s2   <= bp_s1[63:32] * {{16{p8[15]}}, p8};
			y9l_s2   <= {16'd0, by_c[31:0]} * {{32{p9[15]}}, p9};
			y9h_s2   <= by_c[63:32] * {{16{p9[15]}}, p9};
			bp_s2    <= bp_s1;
			by_s2    <= by_c;
			bside_s2 <= bside_s1;
		end
	end

	// B3
	logic [63:0] p8p_c, q2_c;
	assign p8p_c = {{16{p8l_s2[47]}}, p8l_s2} + {p8h_s2, 32'd0};
	assign q2_c  = $signed(p8p_c) >>> 19;

	logic [63:0]    bp_s3, by_s3, q2_s3, y9_s3;
	esc_pkg::side_t bside_s3;
	always_ff @(posedge clk) begin
		if (b_adv[2]) begin
			y9_s3    <= {{16{y9l_s2[47]}}, y9l_s2} + {y9h_s2, 32'd0};
			q2_s3    <= q2_c;
			bp_s3    <= bp_s2;
			by_s3    <= by_s2;
			bside_s3 <= bside_s2;
		end
	end

	// B4: y9 * y, low 64 bits from three partial products
	logic [63:0]    bp_s4, q2_s4, ll_s4;
	logic [31:0]    lh_s4, hl_s4;
	esc_pkg::side_t bside_s4;
	always_ff @(posedge clk) begin
		if (b_adv[3]) begin
			ll_s4    <= {32'd0, y9_s3[31:0]} * {32'd0, by_s3[31:0]};
			lh_s4    <= y9_s3[31:0] * by_s3[63:32];
			hl_s4    <= y9_s3[63:32] * by_s3[31:0];
			bp_s4    <= bp_s3;
			q2_s4    <= q2_s3;
			bside_s4 <= bside_s3;
		end
	end

	// B5
	logic [31:0] cross_c;
	logic [63:0] prod2_c, q1_c;
	assign cross_c = lh_s4 + hl_s4;
	assign prod2_c = ll_s4 + {cross_c, 32'd0};
	assign q1_c    = $signed(prod2_c) >>> 25;

	logic [63:0]    bp_s5, q1_s5, q2_s5;
	esc_pkg::side_t bside_s5;
	always_ff @(posedge clk) begin
		if (b_adv[4]) begin
			q1_s5    <= q1_c;
			bp_s5    <= bp_s4;
			q2_s5    <= q2_s4;
			bside_s5 <= bside_s4;
		end
	end

	// B6
	logic [63:0]    s3_s6;
	esc_pkg::side_t bside_s6;
	always_ff @(posedge clk) begin
		if (b_adv[5]) begin
			s3_s6    <= bp_s5 + q1_s5 + q2_s5;
			bside_s6 <= bside_s5;
		end
	end

	// B7: output register
	logic [31:0]      press_c;
	esc_pkg::result_t res_s7;
	assign press_c = s3_s6[39:8] + {{12{p7[15]}}, p7, 4'd0};

	always_ff @(posedge clk) begin
		if (b_adv[6]) begin
			res_s7.temperature_centi     <= bside_s6.temperature;
			res_s7.pressure_q24_8        <= bside_s6.divisor_zero ? 32'd0 : press_c;
			res_s7.humidity_q22_10       <= bside_s6.humidity;
			res_s7.pressure_divisor_zero <= bside_s6.divisor_zero;
		end
	end

	assign result_valid = b_vld[BS-1];
	assign result       = res_s7;

`ifndef SYNTHESIS
	a_dz_press_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.pressure_divisor_zero |-> result.pressure_q24_8 == 32'd0)
		else $error("pressure not forced to zero on zero divisor");

	a_hum_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.humidity_q22_10 <= 17'd102400)
		else $error("humidity above full scale");

	a_hum_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !hum_en_q |-> result.humidity_q22_10 == 17'd0)
		else $error("humidity nonzero while disabled");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> f_vld[0])
		else $error("accepted sample lost at first stage");
`endif

endmodule

>>> dv/env_sensor_compensation_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// env_sensor_compensation_tb
// Drives raw sample triples and calibration writes into the compensation
// block and checks every compensated record against an in-bench integer model.
// ----------------------------------------------------------------------------
module env_sensor_compensation_tb;

	localparam int PIPE_LAT   = 85;
	localparam int WDOG_LIMIT = 20000;

	// index past the end of the register list
	localparam logic [esc_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 32'd9;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [esc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [63:0] cfg_data;
	logic        sample_valid;
	logic        sample_ready;
	esc_pkg::sample_t sample;
	logic        result_valid;
	logic        result_ready;
	esc_pkg::result_t result;

	// calibration shadow
	logic [47:0] cal_temp;
	logic [63:0] cal_press_a;
	logic [63:0] cal_press_b;
	logic [15:0] cal_p9;
	logic [63:0] cal_hum;
	logic        cal_hum_en;

	esc_pkg::result_t expected_records[$];
	int          err_count = 0;
	int          sent_count;
	int          recv_count = 0;
	int          divzero_seen = 0;
	int          idle_cycles;
	bit          recv_stall_mode;

	env_sensor_compensation dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
		.result_valid(result_valid), .result_ready(result_ready), .result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic signed [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic signed [63:0] sx16w(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	function automatic esc_pkg::result_t compensate(input esc_pkg::sample_t s);
		esc_pkg::result_t r;
		logic signed [31:0] t1, t2, t3, a, b, v1, v2, tf;
		logic signed [63:0] w1, w2, p, q1, q2, pm;
		logic signed [63:0] un, ud, qq;
		logic signed [31:0] h1, h2, h3, h4, h5, h6, x, f1, g, f2, hr, hs;
		t1 = {16'd0, cal_temp[15:0]};
		t2 = sx16(cal_temp[31:16]);
		t3 = sx16(cal_temp[47:32]);
		a  = {15'd0, s.raw_temperature[19:3]} - (t1 <<< 1);
		v1 = (a * t2) >>> 11;
		b  = {16'd0, s.raw_temperature[19:4]} - t1;
		v2 = (((b * b) >>> 12) * t3) >>> 14;
		tf = v1 + v2;
		r.temperature_centi = (tf * 5 + 128) >>> 8;

		w1 = 64'(tf) - 64'sd128000;
		w2 = w1 * w1 * sx16w(cal_press_b[31:16]);
		w2 = w2 + ((w1 * sx16w(cal_press_b[15:0])) <<< 17);
		w2 = w2 + (sx16w(cal_press_a[63:48]) <<< 35);
		w1 = ((w1 * w1 * sx16w(cal_press_a[47:32])) >>> 8)
			+ ((w1 * sx16w(cal_press_a[31:16])) <<< 12);
		w1 = (((64'sd1 <<< 47) + w1) * $signed({48'd0, cal_press_a[15:0]})) >>> 33;
		r.pressure_q24_8 = '0;
		r.pressure_divisor_zero = 1'b0;
		if (w1 == 0) begin
			r.pressure_divisor_zero = 1'b1;
		end else begin
			p  = 64'sd1048576 - $signed({44'd0, s.raw_pressure});
			un = ((p <<< 31) - w2) * 64'sd3125;
			// truncating divide on magnitudes; most-negative / -1 wraps to itself
			ud = w1;
			qq = $signed($unsigned(un[63] ? -un : un) / $unsigned(ud[63] ? -ud : ud));
			p  = (un[63] != ud[63]) ? -qq : qq;
			q1 = (sx16w(cal_p9) * (p >>> 13) * (p >>> 13)) >>> 25;
			q2 = (sx16w(cal_press_b[63:48]) * p) >>> 19;
			pm = ((p + q1 + q2) >>> 8) + (sx16w(cal_press_b[47:32]) <<< 4);
			r.pressure_q24_8 = pm[31:0];
		end

		r.humidity_q22_10 = '0;
		if (cal_hum_en) begin
			h1 = {24'd0, cal_hum[7:0]};
			h2 = sx16(cal_hum[23:8]);
			h3 = {24'd0, cal_hum[31:24]};
			h4 = {{20{cal_hum[43]}}, cal_hum[43:32]};
			h5 = {{20{cal_hum[55]}}, cal_hum[55:44]};
			h6 = {{24{cal_hum[63]}}, cal_hum[63:56]};
			x  = tf - 32'sd76800;
			f1 = (($signed({16'd0, s.raw_humidity}) <<< 14) - (h4 <<< 20) - h5 * x
				+ 32'sd16384) >>> 15;
			g  = (((x * h6) >>> 10) * (((x * h3) >>> 11) + 32'sd32768)) >>> 10;
			g  = g + 32'sd2097152;
			f2 = (g * h2 + 32'sd8192) >>> 14;
			hr = f1 * f2;
			hs = hr >>> 15;
			hr = hr - ((((hs * hs) >>> 7) * h1) >>> 4);
			if (hr < 0) hr = 0;
			if ($unsigned(hr) > esc_pkg::HUM_MAX) hr = esc_pkg::HUM_MAX;
			r.humidity_q22_10 = hr[28:12];
		end
		return r;
	endfunction

	task automatic write_cal(input logic [esc_pkg::CFG_IDX_W-1:0] idx,
		input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			esc_pkg::REG_TEMP_COEFFS:  cal_temp    = val[47:0];
			esc_pkg::REG_PRESS_FIRST:  cal_press_a = val;
			esc_pkg::REG_PRESS_SECOND: cal_press_b = val;
			esc_pkg::REG_PRESS_NINTH:  cal_p9      = val[15:0];
			esc_pkg::REG_HUM_COEFFS:   cal_hum     = val;
			esc_pkg::REG_HUM_ENABLE:   cal_hum_en  = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// holds valid across back-to-back transactions when keep_valid is set
	task automatic send_sample(input esc_pkg::sample_t s, input bit keep_valid);
		sample_valid <= 1'b1;
		sample       <= s;
		do @(posedge clk); while (!sample_ready);
		expected_records.push_back(compensate(s));
		sent_count++;
		if (!keep_valid) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic drain_pipe();
		wait (expected_records.size() == 0);
		repeat (PIPE_LAT + 5) @(posedge clk);
	endtask

	function automatic esc_pkg::sample_t rand_sample();
		esc_pkg::sample_t s;
		s.raw_temperature = 20'($urandom);
		s.raw_pressure    = 20'($urandom);
		s.raw_humidity    = 16'($urandom);
		return s;
	endfunction

	// random bursts with gaps
	task automatic send_random(input int count, input bit typical);
		int left, burst;
		esc_pkg::sample_t s;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 20);
			if (burst > left) burst = left;
			for (int i = 0; i < burst; i++) begin
				s = rand_sample();
				if (typical) begin
					s.raw_temperature = 20'($urandom_range(400000, 650000));
					s.raw_pressure    = 20'($urandom_range(250000, 450000));
				end
				send_sample(s, i != burst - 1);
			end
			left -= burst;
			if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic load_typical_cal();
		write_cal(esc_pkg::REG_TEMP_COEFFS,  {16'd50, 16'd26435, 16'd27504});
		write_cal(esc_pkg::REG_PRESS_FIRST,  {16'd2855, 16'hFFF6, 16'd53, 16'd36477});
		write_cal(esc_pkg::REG_PRESS_SECOND, {16'hFE28, 16'd15500, 16'hFFF9, 16'd140});
		write_cal(esc_pkg::REG_PRESS_NINTH,  64'd6000);
		write_cal(esc_pkg::REG_HUM_COEFFS,   {8'd30, 12'd50, 12'd332, 8'd0, 16'd362, 8'd75});
		write_cal(esc_pkg::REG_HUM_ENABLE,   64'd1);
	endtask

	task automatic test_reset_defaults();
		// all-zero calibration: divisor is zero, humidity on
		send_sample('0, 1'b0);
		send_sample('1, 1'b0);
		drain_pipe();
	endtask

	task automatic test_directed_extremes();
		esc_pkg::sample_t s;
		load_typical_cal();
		for (int i = 0; i < 8; i++) begin
			s.raw_temperature = i[0] ? 20'hFFFFF : 20'h0;
			s.raw_pressure    = i[1] ? 20'hFFFFF : 20'h0;
			s.raw_humidity    = i[2] ? 16'hFFFF : 16'h0;
			send_sample(s, 1'b1);
		end
		send_sample('{20'd519888, 20'd415148, 16'd27000}, 1'b1);
		send_sample('{20'd519888, 20'd415148, 16'd65000}, 1'b1);   // clamp high
		send_sample('{20'd519888, 20'd415148, 16'd0}, 1'b0);       // clamp low
		drain_pipe();
		write_cal(esc_pkg::REG_HUM_ENABLE, 64'd0);
		send_sample('{20'd519888, 20'd415148, 16'd27000}, 1'b0);
		drain_pipe();
		write_cal(esc_pkg::REG_PRESS_FIRST, {cal_press_a[63:16], 16'd0});  // zero divisor
		send_sample('{20'd519888, 20'd415148, 16'd27000}, 1'b0);
		drain_pipe();
		write_cal(esc_pkg::REG_HUM_ENABLE, 64'd1);
		write_cal(REG_UNMAPPED, 64'hDEAD);   // out-of-range index is ignored
		send_sample('{20'd519888, 20'd415148, 16'd27000}, 1'b0);
		drain_pipe();
	endtask

	task automatic test_extreme_cal();
		write_cal(esc_pkg::REG_TEMP_COEFFS,  48'hFFFF_FFFF_FFFF);
		write_cal(esc_pkg::REG_PRESS_FIRST,  64'hFFFF_FFFF_FFFF_FFFF);
		write_cal(esc_pkg::REG_PRESS_SECOND, 64'hFFFF_FFFF_FFFF_FFFF);
		write_cal(esc_pkg::REG_PRESS_NINTH,  64'hFFFF);
		write_cal(esc_pkg::REG_HUM_COEFFS,   64'hFFFF_FFFF_FFFF_FFFF);
		send_random(10, 1'b0);
		drain_pipe();
		write_cal(esc_pkg::REG_TEMP_COEFFS,  48'h7FFF_8000_0000);
		write_cal(esc_pkg::REG_PRESS_FIRST,  64'h8000_7FFF_8000_FFFF);
		write_cal(esc_pkg::REG_PRESS_SECOND, 64'h7FFF_8000_7FFF_8000);
		write_cal(esc_pkg::REG_PRESS_NINTH,  64'h8000);
		write_cal(esc_pkg::REG_HUM_COEFFS,   64'h8080_0800_FF80_00FF);
		send_random(10, 1'b0);
		drain_pipe();
	endtask

	task automatic test_random_cal();
		for (int k = 0; k < 6; k++) begin
			write_cal(esc_pkg::REG_TEMP_COEFFS,  {$urandom, $urandom});
			write_cal(esc_pkg::REG_PRESS_FIRST,  {$urandom, $urandom});
			write_cal(esc_pkg::REG_PRESS_SECOND, {$urandom, $urandom});
			write_cal(esc_pkg::REG_PRESS_NINTH,  64'($urandom));
			write_cal(esc_pkg::REG_HUM_COEFFS,   {$urandom, $urandom});
			write_cal(esc_pkg::REG_HUM_ENABLE,   64'($urandom_range(0, 1)));
			send_random(40, 1'b0);
			drain_pipe();
		end
	endtask

	task automatic test_random_typical();
		load_typical_cal();
		send_random(400, 1'b1);
		drain_pipe();
		write_cal(esc_pkg::REG_HUM_ENABLE, 64'd0);
		send_random(60, 1'b1);
		drain_pipe();
	endtask

	// receiver: alternates between no-stall and random-stall stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready    <= 1'b0;
			recv_stall_mode <= 1'b0;
		end else begin
			if ($urandom_range(0, 199) == 0) recv_stall_mode <= ~recv_stall_mode;
			result_ready <= recv_stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
		end
	end

	always @(posedge clk) begin
		esc_pkg::result_t exp_rec;
		if (arst_n && result_valid && result_ready) begin
			recv_count++;
			if (expected_records.size() == 0) begin
				$display("%0t: unexpected result %h", $time, result);
				err_count++;
			end else begin
				exp_rec = expected_records.pop_front();
				if (exp_rec.pressure_divisor_zero) divzero_seen++;
				if (result.temperature_centi !== exp_rec.temperature_centi) begin
					$display("%0t: temperature exp %0d got %0d", $time,
						exp_rec.temperature_centi, result.temperature_centi);
					err_count++;
				end
				if (result.pressure_q24_8 !== exp_rec.pressure_q24_8) begin
					$display("%0t: pressure exp %h got %h", $time,
						exp_rec.pressure_q24_8, result.pressure_q24_8);
					err_count++;
				end
				if (result.humidity_q22_10 !== exp_rec.humidity_q22_10) begin
					$display("%0t: humidity exp %0d got %0d", $time,
						exp_rec.humidity_q22_10, result.humidity_q22_10);
					err_count++;
				end
				if (result.pressure_divisor_zero !== exp_rec.pressure_divisor_zero) begin
					$display("%0t: divisor flag exp %b got %b", $time,
						exp_rec.pressure_divisor_zero, result.pressure_divisor_zero);
					err_count++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction on any channel
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((sample_valid && sample_ready) || (result_valid && result_ready)
			|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		sample_valid = 1'b0; sample = '0;
		sent_count = 0;
		cal_temp = '0; cal_press_a = '0; cal_press_b = '0; cal_p9 = '0;
		cal_hum = '0; cal_hum_en = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_directed_extremes();
		test_extreme_cal();
		test_random_cal();
		test_random_typical();
		drain_pipe();

		$display("Sent %0d samples, checked %0d records (%0d with zero divisor),",
			sent_count, recv_count, divzero_seen);
		$display("across reset, extreme, random and typical calibration sets.");
		if (err_count == 0 && expected_records.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/esc_pkg.sv
rtl/esc_divider.sv
rtl/env_sensor_compensation.sv
dv/env_sensor_compensation_tb.sv
